[hdl/wsd_pkg.sv]
// Package for the work-stealing task deque: operation codes, beat layouts
// and parameter defaults. No dependencies.
package wsd_pkg;

  // Parameter defaults
  localparam int DEPTH_DEF      = 16;
  localparam int ITEM_WIDTH_DEF = 64;

  // Field widths fixed by the stream format
  localparam int KIND_W   = 2;
  localparam int HANDLE_W = 64;

  // Beat widths, padded to whole bytes
  localparam int IN_DATA_W  = ((KIND_W + HANDLE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((HANDLE_W + 3 + 7) / 8) * 8;

  // Operation codes carried in the kind field
  localparam logic [KIND_W-1:0] KIND_PUSH      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STEAL     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT = 2'd2;

endpackage

[hdl/work_stealing_task_deque.sv]
// Work-stealing task deque: top level holding the entry memory and indices.
// Depends on wsd_pkg.
//
//  channel  | dir | beat                                        | accepted when
//  ---------+-----+---------------------------------------------+--------------------------
//  s_axis   | in  | one deque operation (push / steal / pop)    | s_tvalid && s_tready
//  m_axis   | out | one result per operation                    | m_tvalid && m_tready
//
// Flow: an operation is taken at one edge; the entry memory is read or
// written at that same edge, together with the pending stage, and the result
// register loads from the pending stage whenever the output slot is free.
// Head and tail live in flops, so operations flow at one per cycle while
// no result beat is held back by the receiver.
// Reset clears head, tail and all valid flags and holds s_tready low; the
// entry memory is not cleared, since only entries between head and tail are
// ever returned.
// Stalls: a held result beat stalls the pending stage, and a stalled pending
// stage drops s_tready. The input side keeps flowing while the result beat
// waits, as long as the pending stage is free.
module work_stealing_task_deque
  import wsd_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int ITEM_WIDTH = ITEM_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [1:0] kind, [65:2] push_value, rest zero
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // [63:0] popped_value, [64] got_item,
                                           // [65] push_accepted, [66] now_empty, rest zero
);

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W  = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(DEPTH);
  localparam logic [IDX_W-1:0] ONE_IDX   = IDX_W'(1);

  // Entry memory
  logic [ITEM_WIDTH-1:0] entry_mem [DEPTH];

  logic [IDX_W-1:0] head, head_next;
  logic [IDX_W-1:0] tail, tail_next;

  logic [KIND_W-1:0]     kind;
  logic [ITEM_WIDTH-1:0] push_value;
  logic                  accept;
  logic                  out_free;
  logic                  has_items;
  logic                  do_push, do_steal, do_pop;
  logic [ADDR_W-1:0]     rd_addr;

  // Pending stage: operation outcome waiting for the memory read data
  logic                  pend;
  logic                  pend_got, pend_acc, pend_empty;
  logic [ITEM_WIDTH-1:0] rd_data;

  logic [HANDLE_W-1:0]   popped;

  assign kind       = s_tdata[KIND_W-1:0];
  assign push_value = s_tdata[KIND_W +: ITEM_WIDTH];

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !rst && (!pend || out_free);
  assign accept   = s_tvalid && s_tready;

  assign has_items = tail > head;
  assign do_push   = (kind == KIND_PUSH) && (tail != DEPTH_IDX);
  assign do_steal  = (kind == KIND_STEAL) && has_items;
  assign do_pop    = (kind == KIND_POP_FRONT) && has_items;

  // Index update; rewind both when they meet after a steal or a pop
  always_comb begin
    head_next = head;
    tail_next = tail;
    rd_addr   = head[ADDR_W-1:0];
    if (do_push) begin
      tail_next = tail + ONE_IDX;
    end else if (do_steal) begin
      tail_next = tail - ONE_IDX;
      rd_addr   = tail_next[ADDR_W-1:0];
    end else if (do_pop) begin
      head_next = head + ONE_IDX;
    end
    if ((do_steal || do_pop) && (head_next == tail_next)) begin
      head_next = '0;
      tail_next = '0;
    end
  end

  // Memory: write on push, registered read on every accepted operation
  always_ff @(posedge clk) begin
    if (accept) begin
      if (do_push) begin
        entry_mem[tail[ADDR_W-1:0]] <= push_value;
      end
      rd_data <= entry_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      pend <= 1'b0;
    end else begin
      if (accept) begin
        head <= head_next;
        tail <= tail_next;
      end
      if (accept) begin
        pend <= 1'b1;
      end else if (out_free) begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_got   <= do_steal || do_pop;
      pend_acc   <= do_push;
      pend_empty <= head_next == tail_next;
    end
  end

  assign popped = pend_got ? HANDLE_W'(rd_data) : '0;

  // Result register: load from the pending stage whenever the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= pend;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && pend) begin
      m_tdata <= {(OUT_DATA_W - HANDLE_W - 3)'(0), pend_empty, pend_acc, pend_got, popped};
    end
  end

`ifndef SYNTHESIS
  a_tail_bound : assert property (@(posedge clk) disable iff (rst) tail <= DEPTH_IDX)
    else $error("tail beyond deque depth");
  a_head_le_tail : assert property (@(posedge clk) disable iff (rst) head <= tail)
    else $error("head passed tail");
  a_pend_hold : assert property (@(posedge clk) disable iff (rst)
      pend && !out_free |=> pend && (!pend_got || $stable(rd_data)))
    else $error("pending result lost while output stalled");
  a_one_outcome : assert property (@(posedge clk) disable iff (rst)
      m_tvalid |-> !(m_tdata[HANDLE_W] && m_tdata[HANDLE_W+1]))
    else $error("result reports both a pop and a push");
  a_push_grows : assert property (@(posedge clk) disable iff (rst)
      accept && do_push |=> tail == $past(tail) + ONE_IDX)
    else $error("accepted push did not advance tail");
`endif

endmodule

[test/wsd_tb_pkg.sv]
`timescale 1ns / 100ps
// Scoreboard package for the work-stealing task deque bench: result layout,
// a predictor of the deque and the queue of awaited result beats.
// Depends on wsd_pkg.
package wsd_tb_pkg;
  import wsd_pkg::*;

  // Kind code that the block does not use; it must leave the deque untouched
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int IDX_W = $clog2(DEPTH_DEF + 1);
  localparam logic [HANDLE_W-1:0] HANDLE_MASK =
    {HANDLE_W{1'b1}} >> (HANDLE_W - ITEM_WIDTH_DEF);

  // Same bit order as the low bits of m_tdata
  typedef struct packed {
    logic                now_empty;
    logic                push_accepted;
    logic                got_item;
    logic [HANDLE_W-1:0] popped_value;
  } deque_result_t;

  class deque_scoreboard;
    logic [HANDLE_W-1:0] slots [DEPTH_DEF];
    logic [IDX_W-1:0]    head;
    logic [IDX_W-1:0]    tail;
    deque_result_t       awaited [$];
    int unsigned         errors;

    function new();
      head   = '0;
      tail   = '0;
      errors = 0;
    endfunction

    // Both indices return to the start once the last entry has gone
    function void rewind_when_drained();
      if (head == tail) begin
        head = '0;
        tail = '0;
      end
    endfunction

    function void note_op(logic [KIND_W-1:0] kind, logic [HANDLE_W-1:0] value);
      deque_result_t res;
      logic          has_items;
      res       = '0;
      has_items = tail > head;
      case (kind)
        KIND_PUSH: begin
          if (tail < DEPTH_DEF) begin
            slots[tail]       = value & HANDLE_MASK;
            tail              = tail + 1'b1;
            res.push_accepted = 1'b1;
          end
        end
        KIND_STEAL: begin
          if (has_items) begin
            tail             = tail - 1'b1;
            res.popped_value = slots[tail];
            res.got_item     = 1'b1;
            rewind_when_drained();
          end
        end
        KIND_POP_FRONT: begin
          if (has_items) begin
            res.popped_value = slots[head];
            head             = head + 1'b1;
            res.got_item     = 1'b1;
            rewind_when_drained();
          end
        end
        default: begin
        end
      endcase
      res.popped_value = res.popped_value & HANDLE_MASK;
      res.now_empty    = head == tail;
      awaited.insert(awaited.size(), res);
    endfunction

    function void check_result(deque_result_t actual);
      deque_result_t exp;
      if (awaited.size() == 0) begin
        $error("result beat with nothing awaited: %h", actual);
        errors++;
        return;
      end
      exp = awaited[0];
      awaited.delete(0);
      if (actual.popped_value !== exp.popped_value) begin
        $error("popped_value: expected %h, actual %h", exp.popped_value, actual.popped_value);
        errors++;
      end
      if (actual.got_item !== exp.got_item) begin
        $error("got_item: expected %b, actual %b", exp.got_item, actual.got_item);
        errors++;
      end
      if (actual.push_accepted !== exp.push_accepted) begin
        $error("push_accepted: expected %b, actual %b", exp.push_accepted,
               actual.push_accepted);
        errors++;
      end
      if (actual.now_empty !== exp.now_empty) begin
        $error("now_empty: expected %b, actual %b", exp.now_empty, actual.now_empty);
        errors++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

endpackage

[test/tb_work_stealing_task_deque.sv]
`timescale 1ns / 100ps
// Top-level bench for the work-stealing task deque: drives operation beats,
// checks every result beat against the scoreboard in wsd_tb_pkg.
// Depends on wsd_pkg, wsd_tb_pkg and work_stealing_task_deque.
module tb_work_stealing_task_deque
  import wsd_pkg::*, wsd_tb_pkg::*;
();

  localparam int HOLD_OFF_CYCLES  = 80;    // long receiver hold-off, fills the pipeline
  localparam int WATCHDOG_LIMIT   = 4000;  // cycles with no beat on either side
  localparam int DRAIN_CYCLES     = 8;     // settle time after the last result
  localparam int RANDOM_PER_PHASE = 225;
  localparam int BIAS_SPAN        = 40;    // items per fill / drain / mixed stretch

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;   // [1:0] kind, [65:2] push_value, rest zero
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;         // [63:0] popped_value, [64] got_item,
                                          // [65] push_accepted, [66] now_empty

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests  = 0;  // bumped by the main sequence to ask for a hold-off
  int unsigned hold_served    = 0;  // owned by the receiver process
  int unsigned hold_left      = 0;  // owned by the receiver process
  int unsigned quiet_cycles   = 0;  // owned by the watchdog

  deque_scoreboard sb;

  always #4 clk = ~clk;

  work_stealing_task_deque i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Receiver: stall at random, or hold off for a long stretch on request.
  // Exactly one assignment to m_tready per falling edge.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_OFF_CYCLES - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: check each result beat at the edge that accepts it
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_result(m_tdata[$bits(deque_result_t)-1:0]);
    end
  end

  // Watchdog: end the run if neither side moves a beat for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("work_stealing_task_deque verification failed");
        $finish;
      end
    end
  end

  // Offer one operation beat and hold it until accepted. Leave s_tvalid high
  // afterwards so that back-to-back beats never drop valid within a step.
  task automatic send_op(input logic [KIND_W-1:0] kind, input logic [HANDLE_W-1:0] value);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W - KIND_W - HANDLE_W){1'b0}}, value, kind};
    do @(posedge clk); while (!s_tready);
    sb.note_op(kind, value);
  endtask

  // Task handle with a fair share of all-zero and all-one corners
  function automatic logic [HANDLE_W-1:0] random_handle();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 20) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [KIND_W-1:0] random_kind(int unsigned push_pct);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 3) return KIND_UNUSED;
    if (roll < 3 + push_pct) return KIND_PUSH;
    return $urandom_range(1) ? KIND_STEAL : KIND_POP_FRONT;
  endfunction

  // Alternate fill-heavy, drain-heavy and mixed stretches so the deque
  // swings between empty, full and the dropped-push region in between
  task automatic run_random(input int count);
    int unsigned push_pct;
    for (int i = 0; i < count; i++) begin
      case ((i / BIAS_SPAN) % 3)
        0:       push_pct = 72;
        1:       push_pct = 22;
        default: push_pct = 47;
      endcase
      send_op(random_kind(push_pct), random_handle());
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: corner handles, every kind, a steal on an empty deque
    send_op(KIND_PUSH, '0);
    send_op(KIND_PUSH, '1);
    send_op(KIND_UNUSED, '1);
    send_op(KIND_STEAL, '0);       // takes the all-one handle
    send_op(KIND_POP_FRONT, '1);   // takes the zero handle, deque rewinds
    send_op(KIND_STEAL, '1);       // empty: nothing to take
    // Fill to the end, then push once more: dropped
    for (int i = 0; i <= DEPTH_DEF; i++) begin
      send_op(KIND_PUSH, random_handle());
    end
    // Head moves on but the store is not circular: the next push is still dropped
    send_op(KIND_POP_FRONT, '0);
    send_op(KIND_PUSH, {$urandom, $urandom});

    // No idling; ask for a long hold-off so the block backs up into s_tready
    hold_requests++;
    run_random(RANDOM_PER_PHASE);

    send_idle_pct  = 54;
    recv_stall_pct = 0;
    run_random(RANDOM_PER_PHASE);

    send_idle_pct  = 0;
    recv_stall_pct = 54;
    hold_requests++;
    run_random(RANDOM_PER_PHASE);

    send_idle_pct  = 11;
    recv_stall_pct = 11;
    run_random(RANDOM_PER_PHASE);

    @(negedge clk);
    s_tvalid <= 1'b0;

    // Drain: wait for every awaited beat, then let the pipeline settle
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("work_stealing_task_deque verification clean");
    end else begin
      $display("work_stealing_task_deque verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/wsd_pkg.sv
hdl/work_stealing_task_deque.sv
test/wsd_tb_pkg.sv
test/tb_work_stealing_task_deque.sv
